### design/mexp_pkg.sv
// shared types, token kinds, glyph table and character helpers for the tokenizer
// no dependencies; used by the top level, the datapath and the sequencer
`timescale 1ns / 1ps
`default_nettype none

package mexp_pkg;

    localparam int unsigned MEXP_MAX_BYTES       = 65535;
    localparam int unsigned MEXP_LOOKAHEAD_DEPTH = 4;

    // token kinds
    localparam logic [4:0] KIND_END       = 5'd0;
    localparam logic [4:0] KIND_NUMBER    = 5'd1;
    localparam logic [4:0] KIND_NAME      = 5'd2;
    localparam logic [4:0] KIND_PLUS      = 5'd3;
    localparam logic [4:0] KIND_MINUS     = 5'd4;
    localparam logic [4:0] KIND_STAR      = 5'd5;
    localparam logic [4:0] KIND_SLASH     = 5'd6;
    localparam logic [4:0] KIND_CARET     = 5'd7;
    localparam logic [4:0] KIND_SUPER     = 5'd8;
    localparam logic [4:0] KIND_LPAREN    = 5'd9;
    localparam logic [4:0] KIND_RPAREN    = 5'd10;
    localparam logic [4:0] KIND_LBRACKET  = 5'd11;
    localparam logic [4:0] KIND_RBRACKET  = 5'd12;
    localparam logic [4:0] KIND_COMMA     = 5'd13;
    localparam logic [4:0] KIND_EQUALS    = 5'd14;
    localparam logic [4:0] KIND_ASSIGN    = 5'd15;
    localparam logic [4:0] KIND_APPROX    = 5'd16;
    localparam logic [4:0] KIND_IDENTITY  = 5'd17;
    localparam logic [4:0] KIND_LESS      = 5'd18;
    localparam logic [4:0] KIND_LESSEQ    = 5'd19;
    localparam logic [4:0] KIND_GREATER   = 5'd20;
    localparam logic [4:0] KIND_GREATEREQ = 5'd21;
    localparam logic [4:0] KIND_BAD       = 5'd22;
    // internal marker for the radical glyph, never sent out
    localparam logic [4:0] KIND_RADICAL   = 5'd31;

    // superscript class of a glyph
    localparam logic [1:0] SUP_NONE  = 2'd0;
    localparam logic [1:0] SUP_DIGIT = 2'd1;
    localparam logic [1:0] SUP_MINUS = 2'd2;

    localparam int NGLYPHS = 21;

    localparam logic [1:0] G_LEN [NGLYPHS] = '{
        2'd2, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3,
        2'd3, 2'd2, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3};
    localparam logic [7:0] G_B0 [NGLYPHS] = '{
        8'hCF, 8'hE2, 8'hE2, 8'hE2, 8'hC3, 8'hC2, 8'hE2, 8'hC3, 8'hE2, 8'hE2,
        8'hE2, 8'hC2, 8'hC2, 8'hC2, 8'hE2, 8'hE2, 8'hE2, 8'hE2, 8'hE2, 8'hE2, 8'hE2};
    localparam logic [7:0] G_B1 [NGLYPHS] = '{
        8'h80, 8'h88, 8'h88, 8'h88, 8'h97, 8'hB7, 8'h8B, 8'hB7, 8'h89, 8'h89,
        8'h81, 8'hB9, 8'hB2, 8'hB3, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81};
    localparam logic [7:0] G_B2 [NGLYPHS] = '{
        8'h00, 8'h9E, 8'h92, 8'h9A, 8'h00, 8'h00, 8'h85, 8'h00, 8'hA4, 8'hA5,
        8'hB0, 8'h00, 8'h00, 8'h00, 8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB8, 8'hB9, 8'hBB};
    localparam logic [4:0] G_KIND [NGLYPHS] = '{
        KIND_NAME, KIND_NAME, KIND_MINUS, KIND_RADICAL, KIND_STAR, KIND_STAR,
        KIND_STAR, KIND_SLASH, KIND_LESSEQ, KIND_GREATEREQ,
        KIND_SUPER, KIND_SUPER, KIND_SUPER, KIND_SUPER, KIND_SUPER, KIND_SUPER,
        KIND_SUPER, KIND_SUPER, KIND_SUPER, KIND_SUPER, KIND_SUPER};
    localparam logic [1:0] G_SUP [NGLYPHS] = '{
        SUP_NONE, SUP_NONE, SUP_NONE, SUP_NONE, SUP_NONE, SUP_NONE, SUP_NONE,
        SUP_NONE, SUP_NONE, SUP_NONE,
        SUP_DIGIT, SUP_DIGIT, SUP_DIGIT, SUP_DIGIT, SUP_DIGIT, SUP_DIGIT,
        SUP_DIGIT, SUP_DIGIT, SUP_DIGIT, SUP_DIGIT, SUP_MINUS};

    typedef struct packed {
        logic       full;
        logic       prefix;
        logic [4:0] kind;
        logic [1:0] len;
        logic [1:0] sup;
    } t_gmatch;

    // one token as it leaves the block
    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start_ofs;
        logic [15:0] end_ofs;
        logic        frac;
        logic        sup_valid;
    } t_tok;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic eof;
        logic emit_end;
        logic flush;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic stop;
        logic emits;
        logic pend_valid;
        logic out_free;
    } t_stat;

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_nstart(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == " ") || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
    endfunction

    function automatic logic is_rel(input logic [7:0] c);
        return (c == "=") || (c == ":") || (c == "~") || (c == "<") || (c == ">");
    endfunction

    // single ascii operator kind, two marks a following '='
    function automatic logic [4:0] ascii_kind(input logic [7:0] c, input logic two);
        logic [4:0] k;
        case (c)
            "+":     k = KIND_PLUS;
            "-":     k = KIND_MINUS;
            "*":     k = KIND_STAR;
            "/":     k = KIND_SLASH;
            "^":     k = KIND_CARET;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "[":     k = KIND_LBRACKET;
            "]":     k = KIND_RBRACKET;
            ",":     k = KIND_COMMA;
            "=":     k = two ? KIND_IDENTITY : KIND_EQUALS;
            ":":     k = two ? KIND_ASSIGN : KIND_BAD;
            "~":     k = two ? KIND_APPROX : KIND_BAD;
            "<":     k = two ? KIND_LESSEQ : KIND_LESS;
            ">":     k = two ? KIND_GREATEREQ : KIND_GREATER;
            default: k = KIND_BAD;
        endcase
        return k;
    endfunction

    // glyph lookup over the held bytes, navail is the held count capped at 3
    function automatic t_gmatch glyph_match(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [1:0] navail,
                                            input logic sup_only);
        t_gmatch r;
        logic    eq;
        r = '0;
        for (int i = 0; i < NGLYPHS; i++) begin
            eq = 1'b1;
            if (navail >= 2'd1 && b0 != G_B0[i]) eq = 1'b0;
            if (navail >= 2'd2 && b1 != G_B1[i]) eq = 1'b0;
            if (navail >= 2'd3 && G_LEN[i] == 2'd3 && b2 != G_B2[i]) eq = 1'b0;
            if (sup_only && G_SUP[i] == SUP_NONE) eq = 1'b0;
            if (eq) begin
                if (navail >= G_LEN[i]) begin
                    if (!r.full) begin
                        r.full = 1'b1;
                        r.kind = G_KIND[i];
                        r.len  = G_LEN[i];
                        r.sup  = G_SUP[i];
                    end
                end else begin
                    r.prefix = 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### design/mexp_if.sv
// valid/ready channels for text bytes in and tokens out
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface mexp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       final_byte;
    modport source (output valid, output source_byte, output final_byte, input ready);
    modport sink   (input valid, input source_byte, input final_byte, output ready);
endinterface

interface mexp_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_end;
    logic        has_fraction_or_exponent;
    logic        superscript_valid;
    logic        run_last;
    modport source (output valid, output token_kind, output token_start, output token_end,
                    output has_fraction_or_exponent, output superscript_valid,
                    output run_last, input ready);
    modport sink   (input valid, input token_kind, input token_start, input token_end,
                    input has_fraction_or_exponent, input superscript_valid,
                    input run_last, output ready);
endinterface

`default_nettype wire

### design/math_expression_tokenizer.sv
// top level: byte-in, token-out tokenizer for utf-8 math expressions
// a byte is taken while idle, then the scanner steps decision by decision until it waits
// for more input, and the pending token is then flushed; after the final byte it makes
// its end-of-text decisions, waits and sends the end token before the flush
// a new byte is taken only back in idle, after the flush; a stalled output holds the block
// synchronous active-low reset returns the scanner to offset 0, idle, empty lookahead
`timescale 1ns / 1ps
`default_nettype none

module math_expression_tokenizer
    import mexp_pkg::*;
#(
    parameter int unsigned MAX_BYTES       = MEXP_MAX_BYTES,
    parameter int unsigned LOOKAHEAD_DEPTH = MEXP_LOOKAHEAD_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mexp_in_if.sink    i_in,
    mexp_out_if.source o_out
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    mexp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // scanner datapath
    mexp_datapath #(
        .MAX_BYTES       (MAX_BYTES),
        .LOOKAHEAD_DEPTH (LOOKAHEAD_DEPTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_byte  (i_in.source_byte),
        .o_stat  (stat),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

### design/mexp_datapath.sv
// scanner state, lookahead buffer, one scan decision per stepped cycle, pending and output token
// depends on mexp_pkg and mexp_out_if
`timescale 1ns / 1ps
`default_nettype none

module mexp_datapath
    import mexp_pkg::*;
#(
    parameter int unsigned MAX_BYTES       = MEXP_MAX_BYTES,
    parameter int unsigned LOOKAHEAD_DEPTH = MEXP_LOOKAHEAD_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    input  wire logic [7:0] i_byte,
    output t_stat           o_stat,
    mexp_out_if.source      o_out
);

    localparam int OW   = $clog2(longint'(MAX_BYTES) + 1);
    localparam int SUMW = OW + 1;
    localparam int CW   = $clog2(LOOKAHEAD_DEPTH + 1);
    localparam int IW   = $clog2(LOOKAHEAD_DEPTH);
    localparam int SW   = IW + 3;
    localparam logic [SUMW-1:0] MAXV = SUMW'(MAX_BYTES);

    typedef enum logic [2:0] {
        PH_IDLE, PH_NAME, PH_INT, PH_FRAC, PH_EXP, PH_EXPDIG, PH_SUPER
    } t_phase;

    localparam logic [1:0] ER_WAIT = 2'd0;
    localparam logic [1:0] ER_GO   = 2'd1;
    localparam logic [1:0] ER_BACK = 2'd2;

    logic [OW-1:0] r_off, r_tb;
    t_phase        r_phase;
    logic [7:0]    r_buf [LOOKAHEAD_DEPTH];
    logic [CW-1:0] r_cnt;
    logic          r_dot, r_sbad, r_sfm;
    logic [1:0]    r_scnt;
    t_tok          r_pend, r_out;
    logic          r_pv, r_ov, r_olast;

    // decision outputs
    logic          stop, emits, e_idle, e_frac, e_sv, set_tb;
    logic [4:0]    e_kind;
    logic [2:0]    adv, drop_k;
    t_phase        n_phase;
    logic          n_dot, n_sbad, n_sfm;
    logic [1:0]    n_scnt;
    logic [1:0]    navail;
    t_gmatch       gm;
    logic [7:0]    c;
    logic          two;
    logic [1:0]    er;
    logic [1:0]    ek;
    logic [SUMW-1:0] sum;
    logic [OW-1:0]   off_adv;
    t_tok            e_tok;

    assign c      = r_buf[0];
    assign navail = (r_cnt >= CW'(3)) ? 2'd3 : r_cnt[1:0];
    assign gm     = glyph_match(r_buf[0], r_buf[1], r_buf[2], navail, r_phase == PH_SUPER);
    assign two    = (r_cnt >= CW'(2)) && (r_buf[1] == "=");

    // exponent sign and digit check
    always_comb begin
        er = ER_BACK;
        ek = 2'd0;
        if (r_cnt == '0) begin
            er = ER_WAIT;
        end else if (is_dig(r_buf[0])) begin
            er = ER_GO;
        end else if (r_buf[0] == "+" || r_buf[0] == "-") begin
            ek = 2'd1;
            if (r_cnt < CW'(2)) er = ER_WAIT;
            else er = is_dig(r_buf[1]) ? ER_GO : ER_BACK;
        end else if (r_buf[0] == 8'hE2) begin
            ek = 2'd3;
            if (r_cnt < CW'(2)) er = ER_WAIT;
            else if (r_buf[1] != 8'h88) er = ER_BACK;
            else if (r_cnt < CW'(3)) er = ER_WAIT;
            else if (r_buf[2] != 8'h92) er = ER_BACK;
            else if (r_cnt < CW'(4)) er = ER_WAIT;
            else er = is_dig(r_buf[3]) ? ER_GO : ER_BACK;
        end
    end

    // one scan decision
    always_comb begin
        stop    = 1'b0;
        emits   = 1'b0;
        e_idle  = 1'b0;
        e_frac  = 1'b0;
        e_sv    = 1'b0;
        e_kind  = KIND_END;
        adv     = 3'd0;
        drop_k  = 3'd0;
        set_tb  = 1'b0;
        n_phase = r_phase;
        n_dot   = r_dot;
        n_sbad  = r_sbad;
        n_sfm   = r_sfm;
        n_scnt  = r_scnt;
        case (r_phase)
            PH_IDLE: begin
                if (r_cnt == '0) begin
                    stop = 1'b1;
                end else if (is_ws(c)) begin
                    adv    = 3'd1;
                    drop_k = 3'd1;
                end else if (is_dig(c)) begin
                    set_tb = 1'b1; adv = 3'd1; drop_k = 3'd1; n_dot = 1'b0;
                    n_phase = PH_INT;
                end else if (c == "." && r_cnt < CW'(2) && !i_cmd.eof) begin
                    stop = 1'b1;
                end else if (c == "." && r_cnt >= CW'(2) && is_dig(r_buf[1])) begin
                    set_tb = 1'b1; adv = 3'd1; drop_k = 3'd1; n_dot = 1'b1;
                    n_phase = PH_FRAC;
                end else if (is_nstart(c)) begin
                    set_tb = 1'b1; adv = 3'd1; drop_k = 3'd1; n_dot = 1'b0;
                    n_phase = PH_NAME;
                end else if (!gm.full && gm.prefix && !i_cmd.eof) begin
                    stop = 1'b1;
                end else if (gm.full && gm.sup != SUP_NONE) begin
                    set_tb  = 1'b1;
                    n_sbad  = 1'b0;
                    n_scnt  = 2'd1;
                    n_sfm   = (gm.sup == SUP_MINUS);
                    adv     = {1'b0, gm.len};
                    drop_k  = {1'b0, gm.len};
                    n_phase = PH_SUPER;
                end else if (gm.full && gm.kind == KIND_RADICAL && r_cnt < CW'(4)
                             && !i_cmd.eof) begin
                    stop = 1'b1;
                end else if (gm.full) begin
                    emits  = 1'b1;
                    e_idle = 1'b1;
                    if (gm.kind == KIND_RADICAL)
                        e_kind = (r_cnt >= CW'(4) && r_buf[3] == "(") ? KIND_NAME : KIND_BAD;
                    else
                        e_kind = gm.kind;
                    adv    = {1'b0, gm.len};
                    drop_k = {1'b0, gm.len};
                end else if (is_rel(c) && r_cnt < CW'(2) && !i_cmd.eof) begin
                    stop = 1'b1;
                end else begin
                    emits  = 1'b1;
                    e_idle = 1'b1;
                    e_kind = ascii_kind(c, two);
                    adv    = (two && is_rel(c)) ? 3'd2 : 3'd1;
                    drop_k = (two && is_rel(c)) ? 3'd2 : 3'd1;
                end
            end
            PH_SUPER: begin
                if (gm.full) begin
                    if (gm.sup == SUP_MINUS) begin
                        if (r_scnt != 2'd0) n_sbad = 1'b1;
                        else n_sfm = 1'b1;
                    end
                    if (r_scnt != 2'd2) n_scnt = r_scnt + 2'd1;
                    adv    = {1'b0, gm.len};
                    drop_k = {1'b0, gm.len};
                end else if (gm.prefix && !i_cmd.eof) begin
                    stop = 1'b1;
                end else begin
                    emits   = 1'b1;
                    e_kind  = KIND_SUPER;
                    e_sv    = !r_sbad && !(r_sfm && r_scnt == 2'd1);
                    n_phase = PH_IDLE;
                end
            end
            PH_EXP: begin
                if (er == ER_WAIT && !i_cmd.eof) begin
                    stop = 1'b1;
                end else if (er == ER_GO) begin
                    adv     = 3'({1'b0, ek}) + 3'd2;
                    drop_k  = 3'({1'b0, ek}) + 3'd1;
                    n_dot   = 1'b1;
                    n_phase = PH_EXPDIG;
                end else begin
                    // no exponent digits: number ends, the 'e' opens a name
                    emits   = 1'b1;
                    e_kind  = KIND_NUMBER;
                    e_frac  = r_dot;
                    set_tb  = 1'b1;
                    adv     = 3'd1;
                    n_phase = PH_NAME;
                end
            end
            default: begin
                if (r_cnt == '0) begin
                    if (!i_cmd.eof) begin
                        stop = 1'b1;
                    end else begin
                        emits   = 1'b1;
                        e_kind  = (r_phase == PH_NAME) ? KIND_NAME : KIND_NUMBER;
                        e_frac  = (r_phase == PH_NAME) ? 1'b0 : r_dot;
                        n_phase = PH_IDLE;
                    end
                end else if ((r_phase == PH_NAME) ? (is_nstart(c) || is_dig(c)) : is_dig(c)) begin
                    adv    = 3'd1;
                    drop_k = 3'd1;
                end else if (r_phase == PH_INT && c == ".") begin
                    n_dot   = 1'b1;
                    n_phase = PH_FRAC;
                    adv     = 3'd1;
                    drop_k  = 3'd1;
                end else if ((r_phase == PH_INT || r_phase == PH_FRAC) && (c == "e" || c == "E")) begin
                    drop_k  = 3'd1;
                    n_phase = PH_EXP;
                end else begin
                    emits   = 1'b1;
                    e_kind  = (r_phase == PH_NAME) ? KIND_NAME : KIND_NUMBER;
                    e_frac  = (r_phase == PH_NAME) ? 1'b0 : r_dot;
                    n_phase = PH_IDLE;
                end
            end
        endcase
    end

    // saturating offset advance
    assign sum     = {1'b0, r_off} + SUMW'(adv);
    assign off_adv = (sum > MAXV) ? MAXV[OW-1:0] : sum[OW-1:0];

    always_comb begin
        e_tok.kind      = e_kind;
        e_tok.start_ofs = e_idle ? 16'(r_off) : 16'(r_tb);
        e_tok.end_ofs   = e_idle ? 16'(off_adv) : 16'(r_off);
        e_tok.frac      = e_frac;
        e_tok.sup_valid = e_sv;
    end

    assign o_stat.stop       = stop;
    assign o_stat.emits      = emits;
    assign o_stat.pend_valid = r_pv;
    assign o_stat.out_free   = !r_ov || o_out.ready;

    // lookahead buffer contents
    always_ff @(posedge i_clk) begin
        logic [SW-1:0] src;
        if (i_cmd.load && r_cnt < CW'(LOOKAHEAD_DEPTH)) begin
            r_buf[r_cnt[IW-1:0]] <= i_byte;
        end else if (i_cmd.step) begin
            for (int i = 0; i < LOOKAHEAD_DEPTH; i++) begin
                src = SW'(i) + SW'(drop_k);
                if (src < SW'(LOOKAHEAD_DEPTH)) r_buf[i] <= r_buf[src[IW-1:0]];
            end
        end
    end

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit_end) begin
            r_off   <= '0;
            r_tb    <= '0;
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_dot   <= 1'b0;
            r_sbad  <= 1'b0;
            r_sfm   <= 1'b0;
            r_scnt  <= 2'd0;
        end else if (i_cmd.load) begin
            if (r_cnt < CW'(LOOKAHEAD_DEPTH)) r_cnt <= r_cnt + CW'(1);
        end else if (i_cmd.step) begin
            r_off   <= off_adv;
            if (set_tb) r_tb <= r_off;
            r_phase <= n_phase;
            r_cnt   <= r_cnt - CW'(drop_k);
            r_dot   <= n_dot;
            r_sbad  <= n_sbad;
            r_sfm   <= n_sfm;
            r_scnt  <= n_scnt;
        end
    end

    // pending token and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else if ((i_cmd.step && emits) || i_cmd.emit_end) begin
            // older pending token moves out, the new one takes its place
            if (r_pv) begin
                r_out   <= r_pend;
                r_olast <= 1'b0;
                r_ov    <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            r_pv <= 1'b1;
            if (i_cmd.emit_end) begin
                r_pend.kind      <= KIND_END;
                r_pend.start_ofs <= 16'(r_off);
                r_pend.end_ofs   <= 16'(r_off);
                r_pend.frac      <= 1'b0;
                r_pend.sup_valid <= 1'b0;
            end else begin
                r_pend <= e_tok;
            end
        end else if (i_cmd.flush && r_pv) begin
            r_out   <= r_pend;
            r_olast <= 1'b1;
            r_ov    <= 1'b1;
            r_pv    <= 1'b0;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_out.valid                    = r_ov;
    assign o_out.token_kind               = r_out.kind;
    assign o_out.token_start              = r_out.start_ofs;
    assign o_out.token_end                = r_out.end_ofs;
    assign o_out.has_fraction_or_exponent = r_out.frac;
    assign o_out.superscript_valid        = r_out.sup_valid;
    assign o_out.run_last                 = r_olast;

endmodule

`default_nettype wire

### design/mexp_ctrl.sv
// sequencer: accepts a byte, steps the scanner until it waits, adds end after the final byte, flushes
// depends on mexp_pkg and mexp_in_if
`timescale 1ns / 1ps
`default_nettype none

module mexp_ctrl
    import mexp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mexp_in_if.sink    i_in,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_SCAN_EOF, S_END, S_FLUSH} t_state_e;

    t_state_e r_state, n_state;
    logic     r_final;
    logic     can_emit, go;

    assign can_emit = !i_stat.pend_valid || i_stat.out_free;
    assign go       = !i_stat.stop && (!i_stat.emits || can_emit);

    // commands and next state
    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        i_in.ready = 1'b0;
        o_cmd.eof  = (r_state == S_SCAN_EOF);
        case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.stop) n_state = r_final ? S_SCAN_EOF : S_FLUSH;
                else o_cmd.step = go;
            end
            S_SCAN_EOF: begin
                if (i_stat.stop) n_state = S_END;
                else o_cmd.step = go;
            end
            S_END: begin
                if (can_emit) begin
                    o_cmd.emit_end = 1'b1;
                    n_state        = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!i_stat.pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and final-byte flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load) r_final <= i_in.final_byte;
        end
    end

endmodule

`default_nettype wire
